/* rtl/core/lci_pkg.sv */
// shared constants and types for the line colour interpolator
package lci_pkg;

	localparam int CHAN_BITS = 8;
	localparam int NUM_CHANS = 4;
	localparam int DIV_STEPS = CHAN_BITS;
	localparam int LANE_LAT  = DIV_STEPS + 3;
	localparam int PIPE_LAT  = LANE_LAT + 1;

	localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;
	localparam logic [CHAN_BITS-1:0] CHAN_MIN = '0;

	typedef logic [CHAN_BITS-1:0] chan_t;

endpackage

/* rtl/core/lci_dist.sv */
// manhattan distances from the line start to the point and to the end
module lci_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic        [COORD_BITS:0]   num_s1,
	output logic        [COORD_BITS:0]   den_s1
);

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic        [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + 1'b1) : d;
		return m[COORD_BITS-1:0];
	endfunction

	logic [COORD_BITS:0] num;
	logic [COORD_BITS:0] den_raw;
	logic [COORD_BITS:0] den;

	always_comb begin
		num     = {1'b0, abs_diff(point_x, start_x)} + {1'b0, abs_diff(point_y, start_y)};
		den_raw = {1'b0, abs_diff(end_x, start_x)} + {1'b0, abs_diff(end_y, start_y)};
		den     = (den_raw == '0) ? (COORD_BITS+1)'(1) : den_raw;
	end

	always_ff @(posedge clk) begin
		num_s1 <= num;
		den_s1 <= den;
	end

endmodule

/* rtl/core/lci_lane.sv */
// one colour channel: span times distance, restoring divide, saturate
module lci_lane import lci_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  chan_t               s_chan,
	input  chan_t               e_chan,
	input  logic [COORD_BITS:0] num,
	input  logic [COORD_BITS:0] den,
	output chan_t               chan_out
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + CHAN_BITS;

	chan_t          s_s2, s_s3;
	logic           rise_s2, rise_s3;
	logic [PW-1:0]  prod_s2, rem_s3;
	logic [DW-1:0]  den_s2, den_s3;
	logic           ovf_s3;

	logic [PW-1:0]  rem_sd  [DIV_STEPS];
	chan_t          quo_sd  [DIV_STEPS];
	logic [DW-1:0]  den_sd  [DIV_STEPS];
	chan_t          s_sd    [DIV_STEPS];
	logic           rise_sd [DIV_STEPS];
	logic           ovf_sd  [DIV_STEPS];

	chan_t          span;
	logic [CHAN_BITS:0] sum;
	chan_t          res;

	always_comb begin
		span = (s_chan < e_chan) ? (e_chan - s_chan) : (s_chan - e_chan);
	end

	always_ff @(posedge clk) begin
		s_s2    <= s_chan;
		rise_s2 <= s_chan < e_chan;
		prod_s2 <= PW'(span) * PW'(num);
		den_s2  <= den;
	end

	always_ff @(posedge clk) begin
		s_s3    <= s_s2;
		rise_s3 <= rise_s2;
		rem_s3  <= prod_s2;
		den_s3  <= den_s2;
		ovf_s3  <= prod_s2 >= {den_s2, {CHAN_BITS{1'b0}}};
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int BIT = DIV_STEPS - 1 - k;
		logic [PW-1:0] rem_in;
		logic [DW-1:0] den_in;
		chan_t         quo_in;
		chan_t         s_in;
		logic          rise_in;
		logic          ovf_in;
		logic [PW-1:0] dsh;
		logic          ge;

		if (k == 0) begin : g_first
			always_comb begin
				rem_in  = rem_s3;
				den_in  = den_s3;
				quo_in  = '0;
				s_in    = s_s3;
				rise_in = rise_s3;
				ovf_in  = ovf_s3;
			end
		end else begin : g_next
			always_comb begin
				rem_in  = rem_sd[k-1];
				den_in  = den_sd[k-1];
				quo_in  = quo_sd[k-1];
				s_in    = s_sd[k-1];
				rise_in = rise_sd[k-1];
				ovf_in  = ovf_sd[k-1];
			end
		end

		always_comb begin
			dsh = PW'(den_in) << BIT;
			ge  = rem_in >= dsh;
		end

		always_ff @(posedge clk) begin
			rem_sd[k]  <= ge ? (rem_in - dsh) : rem_in;
			quo_sd[k]  <= quo_in | (chan_t'(ge) << BIT);
			den_sd[k]  <= den_in;
			s_sd[k]    <= s_in;
			rise_sd[k] <= rise_in;
			ovf_sd[k]  <= ovf_in;
		end
	end

	always_comb begin
		sum = {1'b0, s_sd[DIV_STEPS-1]} + {1'b0, quo_sd[DIV_STEPS-1]};
		if (rise_sd[DIV_STEPS-1]) begin
			res = (ovf_sd[DIV_STEPS-1] || sum[CHAN_BITS]) ? CHAN_MAX : sum[CHAN_BITS-1:0];
		end else begin
			res = (ovf_sd[DIV_STEPS-1] || (quo_sd[DIV_STEPS-1] > s_sd[DIV_STEPS-1]))
				? CHAN_MIN : (s_sd[DIV_STEPS-1] - quo_sd[DIV_STEPS-1]);
		end
	end

	always_ff @(posedge clk) begin
		chan_out <= res;
	end

endmodule

/* rtl/core/line_colour_interpolator.sv */
// top level of the line colour interpolator
//
// usage: drive the six coordinates and the two 32-bit colours and pulse
// start; a request is taken at every rising edge where start is high and
// busy is low. busy never rises, so one request can be taken every cycle.
// each request yields exactly one mixed_colour, shown for one cycle with
// done high, once the request has passed through the distance stage and
// every lane stage.
// the path is one distance stage, then four channel lanes in parallel, each
// with a multiply stage, a range check stage, eight restoring divide stages
// (one quotient bit each) and a saturate stage; the lane outputs are joined
// into mixed_colour. throughput is one request per cycle.
// reset clears the valid pipeline only, so no done pulse appears for
// requests in flight at reset. the receiver cannot stall: a result must be
// captured in the cycle that done is high.
module line_colour_interpolator import lci_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic        [31:0]           start_colour,
	input  logic        [31:0]           end_colour,
	output logic                         done,
	output logic        [31:0]           mixed_colour
);

	logic [COORD_BITS:0] num_s1;
	logic [COORD_BITS:0] den_s1;
	logic [31:0]         start_colour_s1;
	logic [31:0]         end_colour_s1;
	logic [PIPE_LAT-1:0] vld_q;
	chan_t               lane_out [NUM_CHANS];

	assign busy = 1'b0;

	lci_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk     (clk),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.point_x (point_x),
		.point_y (point_y),
		.num_s1  (num_s1),
		.den_s1  (den_s1)
	);

	always_ff @(posedge clk) begin
		start_colour_s1 <= start_colour;
		end_colour_s1   <= end_colour;
	end

	for (genvar c = 0; c < NUM_CHANS; c++) begin : g_lane
		lci_lane #(
			.COORD_BITS(COORD_BITS)
		) u_lane (
			.clk      (clk),
			.s_chan   (start_colour_s1[c*CHAN_BITS +: CHAN_BITS]),
			.e_chan   (end_colour_s1[c*CHAN_BITS +: CHAN_BITS]),
			.num      (num_s1),
			.den      (den_s1),
			.chan_out (lane_out[c])
		);
		assign mixed_colour[c*CHAN_BITS +: CHAN_BITS] = lane_out[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[PIPE_LAT-1];

	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a request");

	a_point_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(point_x == start_x && point_y == start_y, PIPE_LAT)
		|-> mixed_colour == $past(start_colour, PIPE_LAT))
		else $error("point at start must give start colour");

	a_point_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(point_x == end_x && point_y == end_y
			&& (start_x != end_x || start_y != end_y), PIPE_LAT)
		|-> mixed_colour == $past(end_colour, PIPE_LAT))
		else $error("point at end must give end colour");

	a_equal_channel: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start_colour[31:24] == end_colour[31:24], PIPE_LAT)
		|-> mixed_colour[31:24] == $past(start_colour[31:24], PIPE_LAT))
		else $error("equal channel must pass through");

endmodule
